// ===== rtl/core/kls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kls_pkg
// Shared constants, codes and types of the keyframe linear sampler.
// -----------------------------------------------------------------------------
package kls_pkg;

	localparam int MAX_KEYS_DEF = 32;

	// Operation codes of an input word.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PLAYING = 2'd0;
	localparam logic [1:0] REG_TPS     = 2'd1;
	localparam logic [1:0] REG_LOOP    = 2'd2;

	localparam logic        PLAYING_RESET = 1'b1;
	localparam logic [15:0] TPS_RESET     = 16'd1;
	localparam logic [31:0] LOOP_RESET    = 32'h0001_0000;

	// Shared divider widths.
	localparam int DIVD_W = 49;
	localparam int DIVS_W = 33;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} kls_entry_t;

	typedef struct packed {
		logic latch_item;
		logic clr_counts;
		logic do_insert;
		logic load_sum;
		logic load_pt_direct;
		logic load_pt_rem;
		logic div_start;
		logic div_frac;
		logic set_ch0;
		logic set_ch1;
		logic idx_zero;
		logic idx_inc;
		logic load_prev;
		logic load_cur;
		logic set_single;
		logic set_notfound;
		logic set_f_zero;
		logic load_f;
		logic mul_go;
		logic acc;
		logic out_load;
	} kls_cmd_t;

	typedef struct packed {
		logic playing;
		logic is_insert;
		logic ld_zero;
		logic div_done;
		logic cnt_zero;
		logic cnt_one;
		logic found;
		logic idx_end;
		logic den_zero;
		logic coord_last;
		logic ch_is1;
		logic out_free;
	} kls_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/kls_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kls_if
// Valid/ready channels carrying input words and result words.
// -----------------------------------------------------------------------------
interface kls_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic        channel;
	logic [31:0] key_time;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	logic [31:0] delta_seconds;

	modport source(output valid, op, channel, key_time, value_x, value_y, value_z,
		delta_seconds, input ready);
	modport sink(input valid, op, channel, key_time, value_x, value_y, value_z,
		delta_seconds, output ready);
endinterface

interface kls_out_if;
	logic        valid;
	logic        ready;
	logic        out_channel;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0]  status;
	logic        last;

	modport source(output valid, out_channel, out_x, out_y, out_z, status, last,
		input ready);
	modport sink(input valid, out_channel, out_x, out_y, out_z, status, last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kls_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module kls_div import kls_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DIVS_W-1:0] divisor,
	output logic                   done,
	output logic [DIVD_W-1:0]      quo,
	output logic [DIVS_W-1:0]      rem
);
	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   shifted;
	logic [DIVS_W+1:0] diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge      = !diff[DIVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/kls_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kls_dp
// Datapath: key memory, play time, bracket search, factor and interpolation.
// -----------------------------------------------------------------------------
module kls_dp import kls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire kls_cmd_t    cmd,
	output kls_sts_t         sts,
	input  wire logic        playing,
	input  wire logic [15:0] ticks_per_second,
	input  wire logic [31:0] loop_duration,
	input  wire logic [1:0]  op,
	input  wire logic        channel,
	input  wire logic [31:0] key_time,
	input  wire logic [31:0] value_x,
	input  wire logic [31:0] value_y,
	input  wire logic [31:0] value_z,
	input  wire logic [31:0] delta_seconds,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic             out_channel,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [31:0]      out_z,
	output logic [1:0]       status,
	output logic             last
);
	localparam int DEPTH = 2 * MAX_KEYS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_KEYS);
	localparam int CW    = $clog2(MAX_KEYS + 1);

	kls_entry_t mem [DEPTH];
	kls_entry_t rd_q, prev_q, cur_q;

	logic [1:0]  op_q;
	logic        chi_q;
	kls_entry_t  item_q;
	logic [31:0] delta_q;
	logic [31:0] pt_q;
	logic [48:0] sum_q;
	logic [CW-1:0] cnt_s_q, cnt_p_q;
	logic        ch_q;
	logic [IW-1:0] idx_q;
	logic        neg_q;
	logic signed [31:0] f_q;
	logic [1:0]  k_q;
	logic signed [64:0] prod_s1;
	logic [31:0] res_x_q, res_y_q, res_z_q;
	logic [1:0]  res_st_q;
	logic        out_valid_q;

	logic [CW-1:0] cnt_cur, cnt_ins;
	logic          ins_full;
	logic [AW-1:0] raddr, waddr;
	logic signed [32:0] diff, den;
	logic [32:0]   diff_abs, den_abs;
	logic [DIVD_W-1:0] div_dvd;
	logic [DIVS_W-1:0] div_dsr;
	logic          div_done;
	logic [DIVD_W-1:0] div_quo;
	logic [DIVS_W-1:0] div_rem;
	logic [31:0]   v0, v1;
	logic signed [32:0] dv;
	logic signed [48:0] sh;
	logic signed [49:0] sumv;
	logic [31:0]   satv;
	logic [31:0]   f_next;

	assign cnt_cur  = ch_q ? cnt_p_q : cnt_s_q;
	assign cnt_ins  = chi_q ? cnt_p_q : cnt_s_q;
	assign ins_full = (cnt_ins == CW'(MAX_KEYS));
	assign raddr    = ch_q ? AW'(MAX_KEYS) + AW'(idx_q) : AW'(idx_q);
	assign waddr    = chi_q ? AW'(MAX_KEYS) + AW'(cnt_ins) : AW'(cnt_ins);

	always_ff @(posedge clk) begin
		if (cmd.do_insert && !ins_full) begin
			mem[waddr] <= item_q;
		end
		rd_q <= mem[raddr];
	end

	// Fraction operands: the bracket is prev_q (earlier key) and cur_q.
	assign diff     = $signed({1'b0, pt_q}) - $signed({1'b0, prev_q.t});
	assign den      = $signed({1'b0, cur_q.t}) - $signed({1'b0, prev_q.t});
	assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
	assign den_abs  = den[32] ? 33'(-den) : 33'(den);
	assign div_dvd  = cmd.div_frac ? {diff_abs, 16'h0000} : sum_q;
	assign div_dsr  = cmd.div_frac ? den_abs : {1'b0, loop_duration};

	kls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Truncated quotient with its sign restored, saturated to 32 bits.
	always_comb begin
		if (!neg_q) begin
			f_next = (div_quo > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end else begin
			f_next = (div_quo > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
		end
	end

	always_comb begin
		unique case (k_q)
			2'd0:    begin v0 = prev_q.x; v1 = cur_q.x; end
			2'd1:    begin v0 = prev_q.y; v1 = cur_q.y; end
			default: begin v0 = prev_q.z; v1 = cur_q.z; end
		endcase
	end

	assign dv   = $signed({v1[31], v1}) - $signed({v0[31], v0});
	assign sh   = prod_s1[64:16];
	assign sumv = $signed({sh[48], sh}) + $signed({{18{v0[31]}}, v0});

	always_comb begin
		if (sumv[49:31] == {19{sumv[49]}}) begin
			satv = sumv[31:0];
		end else begin
			satv = sumv[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q        <= '0;
			cnt_s_q     <= '0;
			cnt_p_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_counts) begin
				cnt_s_q <= '0;
				cnt_p_q <= '0;
			end else if (cmd.do_insert && !ins_full) begin
				if (chi_q) begin
					cnt_p_q <= cnt_p_q + CW'(1);
				end else begin
					cnt_s_q <= cnt_s_q + CW'(1);
				end
			end
			if (cmd.load_pt_direct) begin
				pt_q <= sum_q[31:0];
			end else if (cmd.load_pt_rem) begin
				pt_q <= div_rem[31:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			op_q    <= op;
			chi_q   <= channel;
			item_q  <= '{t: key_time, x: value_x, y: value_y, z: value_z};
			delta_q <= delta_seconds;
		end
		if (cmd.load_sum) begin
			sum_q <= {17'h0, pt_q} + {1'b0, {16'h0, delta_q} * {32'h0, ticks_per_second}};
		end
		if (cmd.set_ch0) begin
			ch_q <= 1'b0;
		end else if (cmd.set_ch1) begin
			ch_q <= 1'b1;
		end
		if (cmd.idx_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.load_prev) begin
			prev_q <= rd_q;
		end
		if (cmd.load_cur) begin
			cur_q    <= rd_q;
			k_q      <= 2'd0;
			res_st_q <= ST_OK;
		end
		if (cmd.div_start) begin
			neg_q <= diff[32] ^ den[32];
		end
		if (cmd.set_f_zero) begin
			f_q <= '0;
		end else if (cmd.load_f) begin
			f_q <= f_next;
		end
		if (cmd.mul_go) begin
			prod_s1 <= dv * f_q;
		end
		if (cmd.acc) begin
			k_q <= k_q + 2'd1;
			unique case (k_q)
				2'd0:    res_x_q <= satv;
				2'd1:    res_y_q <= satv;
				default: res_z_q <= satv;
			endcase
		end
		if (cmd.set_single) begin
			res_x_q  <= rd_q.x;
			res_y_q  <= rd_q.y;
			res_z_q  <= rd_q.z;
			res_st_q <= ST_OK;
		end else if (cmd.set_notfound || cmd.do_insert) begin
			res_x_q  <= '0;
			res_y_q  <= '0;
			res_z_q  <= '0;
			res_st_q <= cmd.set_notfound ? ST_NOT_FOUND : (ins_full ? ST_FULL : ST_OK);
		end
		if (cmd.out_load) begin
			out_x  <= res_x_q;
			out_y  <= res_y_q;
			out_z  <= res_z_q;
			status <= res_st_q;
			if (op_q == OP_INSERT) begin
				out_channel <= chi_q;
				last        <= 1'b1;
			end else begin
				out_channel <= ch_q;
				last        <= ch_q || (cnt_p_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.playing    = playing;
		sts.is_insert  = (op_q == OP_INSERT);
		sts.ld_zero    = (loop_duration == '0);
		sts.div_done   = div_done;
		sts.cnt_zero   = (cnt_cur == '0);
		sts.cnt_one    = (cnt_cur == CW'(1));
		sts.found      = (pt_q < rd_q.t);
		sts.idx_end    = ((CW'(idx_q) + CW'(1)) >= cnt_cur);
		sts.den_zero   = (den == '0);
		sts.coord_last = (k_q == 2'd2);
		sts.ch_is1     = ch_q;
		sts.out_free   = !out_valid_q || out_ready;
	end
endmodule
`default_nettype wire

// ===== rtl/core/kls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// kls_ctrl
// Sequencer that steps the datapath through time advance, search and blend.
// -----------------------------------------------------------------------------
module kls_ctrl import kls_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_op,
	output logic            in_ready,
	input  wire kls_sts_t   sts,
	output kls_cmd_t        cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ADV   = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_MODW  = 4'd3;
	localparam logic [3:0] S_CHAN  = 4'd4;
	localparam logic [3:0] S_RD0   = 4'd5;
	localparam logic [3:0] S_FIRST = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_CMP   = 4'd8;
	localparam logic [3:0] S_FRAC  = 4'd9;
	localparam logic [3:0] S_DIVW  = 4'd10;
	localparam logic [3:0] S_MUL   = 4'd11;
	localparam logic [3:0] S_ACC   = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;
	localparam logic [3:0] S_NEXT  = 4'd14;
	localparam logic [3:0] S_INS   = 4'd15;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					unique case (in_op)
						OP_TICK:   state_d = sts.playing ? S_ADV : S_IDLE;
						OP_INSERT: state_d = S_INS;
						OP_CLEAR:  cmd.clr_counts = 1'b1;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADV: begin
				cmd.load_sum = 1'b1;
				state_d      = S_MOD;
			end
			S_MOD: begin
				if (sts.ld_zero) begin
					cmd.load_pt_direct = 1'b1;
					cmd.set_ch0        = 1'b1;
					state_d            = S_CHAN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_MODW;
				end
			end
			S_MODW: begin
				if (sts.div_done) begin
					cmd.load_pt_rem = 1'b1;
					cmd.set_ch0     = 1'b1;
					state_d         = S_CHAN;
				end
			end
			S_CHAN: begin
				if (sts.cnt_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.idx_zero = 1'b1;
					state_d      = S_RD0;
				end
			end
			S_RD0: state_d = S_FIRST;
			S_FIRST: begin
				cmd.load_prev = 1'b1;
				if (sts.cnt_one) begin
					cmd.set_single = 1'b1;
					state_d        = S_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (sts.found) begin
					cmd.load_cur = 1'b1;
					state_d      = S_FRAC;
				end else if (sts.idx_end) begin
					cmd.set_notfound = 1'b1;
					state_d          = S_EMIT;
				end else begin
					cmd.load_prev = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = S_RD;
				end
			end
			S_FRAC: begin
				if (sts.den_zero) begin
					cmd.set_f_zero = 1'b1;
					state_d        = S_MUL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_frac  = 1'b1;
					state_d       = S_DIVW;
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.load_f = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.coord_last ? S_EMIT : S_MUL;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sts.is_insert ? S_IDLE : S_NEXT;
				end
			end
			S_NEXT: begin
				if (sts.ch_is1) begin
					state_d = S_IDLE;
				end else begin
					cmd.set_ch1 = 1'b1;
					state_d     = S_CHAN;
				end
			end
			S_INS: begin
				cmd.do_insert = 1'b1;
				state_d       = S_EMIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/keyframe_linear_sampler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Insert writes the key and ends in one result word; clear and a paused tick give none.
// Tick: the time advance, then the modulo divide when the loop duration is non-zero,
// then per non-empty channel the key search, the fraction in the shared 49-step
// divider and the three multiply-adds.
// One word is processed at a time; the result register lets the next word enter.
// Reset clears play time and key counts and restores the register defaults.
// -----------------------------------------------------------------------------
// keyframe_linear_sampler_unit
// Two keyframe tables sampled by linear interpolation on every tick while playing.
// -----------------------------------------------------------------------------
module keyframe_linear_sampler_unit import kls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kls_in_if.sink           req,
	kls_out_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic        playing_q;
	logic [15:0] tps_q;
	logic [31:0] loop_q;
	kls_cmd_t    cmd;
	kls_sts_t    sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= PLAYING_RESET;
			tps_q     <= TPS_RESET;
			loop_q    <= LOOP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_PLAYING: playing_q <= pwdata[0];
				REG_TPS:     tps_q     <= pwdata[15:0];
				REG_LOOP:    loop_q    <= pwdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PLAYING: prdata = {31'h0, playing_q};
			REG_TPS:     prdata = {16'h0, tps_q};
			REG_LOOP:    prdata = loop_q;
			default:     prdata = '0;
		endcase
	end

	kls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kls_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.playing          (playing_q),
		.ticks_per_second (tps_q),
		.loop_duration    (loop_q),
		.op               (req.op),
		.channel          (req.channel),
		.key_time         (req.key_time),
		.value_x          (req.value_x),
		.value_y          (req.value_y),
		.value_z          (req.value_z),
		.delta_seconds    (req.delta_seconds),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_channel      (rsp.out_channel),
		.out_x            (rsp.out_x),
		.out_y            (rsp.out_y),
		.out_z            (rsp.out_z),
		.status           (rsp.status),
		.last             (rsp.last)
	);
endmodule
`default_nettype wire

// ===== dv/kls_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kls_checker
// Watches the request, result and register channels of the keyframe linear
// sampler, predicts every result word from its own copy of the tables, the
// play time and the registers, and compares each result word as it leaves.
// -----------------------------------------------------------------------------
module kls_checker import kls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kls_in_if           req,
	kls_out_if          rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        ch;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  st;
		logic        last;
	} sample_word_t;

	sample_word_t expected_words[$];

	logic        playing_q;
	logic [15:0] tps_q;
	logic [31:0] loop_q;
	logic [31:0] play_t;
	kls_entry_t  keys[2][MAX_KEYS];
	int          key_cnt[2];

	assign pending = expected_words.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
		longint v0, v1, p, q;
		v0 = $signed(a);
		v1 = $signed(b);
		p = (v1 - v0) * f;
		q = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
		return clip32(v0 + q);
	endfunction

	function automatic sample_word_t sample_channel(int ch);
		sample_word_t w;
		int i;
		longint t0, t1, ptl, den, f;
		w = '0;
		w.ch = ch[0];
		w.st = ST_OK;
		if (key_cnt[ch] == 1) begin
			w.x = keys[ch][0].x;
			w.y = keys[ch][0].y;
			w.z = keys[ch][0].z;
			return w;
		end
		for (i = 1; i < key_cnt[ch]; i++)
			if (play_t < keys[ch][i].t)
				break;
		if (i >= key_cnt[ch]) begin
			w.st = ST_NOT_FOUND;
			return w;
		end
		t0 = keys[ch][i-1].t;
		t1 = keys[ch][i].t;
		ptl = play_t;
		den = t1 - t0;
		f = (den == 0) ? 0 : clip32(((ptl - t0) * 65536) / den);
		w.x = blend(keys[ch][i-1].x, keys[ch][i].x, f);
		w.y = blend(keys[ch][i-1].y, keys[ch][i].y, f);
		w.z = blend(keys[ch][i-1].z, keys[ch][i].z, f);
		return w;
	endfunction

	task automatic predict_word();
		sample_word_t w;
		logic [63:0] sum;
		int first;
		case (req.op)
			OP_TICK: begin
				if (playing_q) begin
					sum = 64'(play_t) + 64'(req.delta_seconds) * 64'(tps_q);
					play_t = (loop_q == 0) ? sum[31:0] : 32'(sum % 64'(loop_q));
					first = expected_words.size();
					if (key_cnt[0] > 0)
						expected_words.push_back(sample_channel(0));
					if (key_cnt[1] > 0)
						expected_words.push_back(sample_channel(1));
					if (expected_words.size() > first)
						expected_words[$].last = 1'b1;
				end
			end
			OP_INSERT: begin
				w = '0;
				w.ch = req.channel;
				w.last = 1'b1;
				if (key_cnt[req.channel] < MAX_KEYS) begin
					keys[req.channel][key_cnt[req.channel]] =
						{req.key_time, req.value_x, req.value_y, req.value_z};
					key_cnt[req.channel]++;
					w.st = ST_OK;
				end else begin
					w.st = ST_FULL;
				end
				expected_words.push_back(w);
			end
			OP_CLEAR: begin
				key_cnt[0] = 0;
				key_cnt[1] = 0;
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: result mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_word_t w;
		if (!arst_n) begin
			playing_q = PLAYING_RESET;
			tps_q = TPS_RESET;
			loop_q = LOOP_RESET;
			play_t = '0;
			key_cnt[0] = 0;
			key_cnt[1] = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected", $realtime);
					fail_count++;
				end else begin
					w = expected_words.pop_front();
					if (rsp.out_channel !== w.ch) report("out_channel", rsp.out_channel, w.ch);
					if (rsp.out_x !== w.x) report("out_x", rsp.out_x, w.x);
					if (rsp.out_y !== w.y) report("out_y", rsp.out_y, w.y);
					if (rsp.out_z !== w.z) report("out_z", rsp.out_z, w.z);
					if (rsp.status !== w.st) report("status", rsp.status, w.st);
					if (rsp.last !== w.last) report("last", rsp.last, w.last);
				end
			end
			if (req.valid && req.ready)
				predict_word();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PLAYING: playing_q = pwdata[0];
					REG_TPS:     tps_q = pwdata[15:0];
					REG_LOOP:    loop_q = pwdata;
					default: ;
				endcase
			end
		end
	end

	initial fail_count = 0;

endmodule

// ===== dv/tb_keyframe_linear_sampler_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_keyframe_linear_sampler_unit
// Drives directed and random request words and register writes into the
// sampler under random idling and back-pressure, and gives the verdict.
// -----------------------------------------------------------------------------
module tb_keyframe_linear_sampler_unit;
	import kls_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int DRAIN_CYCLES   = 500;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending;
	int          in_idle, out_idle;
	int          hold_trig;
	int          words_sent;
	int          quiet;
	logic [31:0] loop_now;
	logic [15:0] tps_now;

	kls_in_if  req_if();
	kls_out_if rsp_if();

	keyframe_linear_sampler_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	kls_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Result receiver; a long hold-off is started whenever hold_trig moves.
	initial begin
		int seen, hold_left;
		seen = 0;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_trig != seen) begin
				seen = hold_trig;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= out_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LOOP)
			loop_now = data;
		if (idx == REG_TPS)
			tps_now = data[15:0];
	endtask

	// Waits until every result word has come and the block has gone quiet.
	task automatic settle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send(logic [1:0] op, logic ch, logic [31:0] t, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] d);
		if ($urandom_range(99) < in_idle) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.channel <= ch;
		req_if.key_time <= t;
		req_if.value_x <= x;
		req_if.value_y <= y;
		req_if.value_z <= z;
		req_if.delta_seconds <= d;
		do @(posedge clk); while (!req_if.ready);
		words_sent++;
	endtask

	task automatic insert_key(logic ch, logic [31:0] t, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		send(OP_INSERT, ch, t, x, y, z, $urandom);
	endtask

	task automatic tick(logic [31:0] d);
		send(OP_TICK, 1'($urandom), $urandom, $urandom, $urandom, $urandom, d);
	endtask

	task automatic clear_keys();
		send(OP_CLEAR, 1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// A clear, up to five keys per channel (now and then 30 to 34) in non-decreasing time, then a run of ticks.
	task automatic keyframe_run();
		longint span, acc, step_max, dmax;
		int n;
		span = (loop_now == 0) ? 64'hFFFF_FFFF : loop_now;
		clear_keys();
		for (int ch = 0; ch < 2; ch++) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 5);
			acc = $urandom_range(0, 32'(span / 4));
			step_max = span / (n + 1);
			for (int k = 0; k < n; k++) begin
				insert_key(ch[0], (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc),
					$urandom, $urandom, $urandom);
				if ($urandom_range(9) != 0)
					acc += $urandom_range(0, 32'(step_max));
			end
		end
		dmax = span / (3 * ((tps_now == 0) ? 1 : tps_now));
		repeat ($urandom_range(1, 6))
			tick(($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 32'(dmax)));
	endtask

	task automatic noise_word();
		send(2'($urandom_range(0, 3)), 1'($urandom), $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.op = OP_TICK;
		req_if.channel = 1'b0;
		req_if.key_time = '0;
		req_if.value_x = '0;
		req_if.value_y = '0;
		req_if.value_z = '0;
		req_if.delta_seconds = '0;
		in_idle = 0;
		out_idle = 0;
		hold_trig = 0;
		words_sent = 0;
		quiet = 0;
		loop_now = LOOP_RESET;
		tps_now = TPS_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: empty tables, single keys, extreme values, equal times,
		// keys out of order, the unused op and clear.
		apb_write(REG_PLAYING, 32'd1);
		apb_write(REG_TPS, 32'd1);
		apb_write(REG_LOOP, LOOP_RESET);
		tick(32'h0001_0000);
		insert_key(1'b0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		tick(32'h0000_1000);
		insert_key(1'b0, 32'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		insert_key(1'b1, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
		insert_key(1'b1, 32'h0, 32'h0002_0000, 32'h1, 32'h7FFF_FFFF);
		tick(32'h0000_4000);
		insert_key(1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h8000_0000);
		tick(32'h0000_8000);
		send(2'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		clear_keys();
		tick(32'h0000_2000);
		insert_key(1'b1, 32'h0002_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0);
		insert_key(1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
		tick(32'h0000_0100);
		settle();
		apb_write(REG_PLAYING, 32'd0);
		tick(32'h0000_1000);
		settle();
		apb_write(REG_PLAYING, 32'd1);
		apb_write(REG_TPS, 32'd0);
		tick(32'hFFFF_FFFF);
		settle();
		apb_write(REG_TPS, 32'd65535);
		apb_write(REG_LOOP, 32'd0);
		tick(32'hFFFF_FFFF);
		settle();
		apb_write(REG_LOOP, 32'hFFFF_FFFF);
		tick(32'hFFFF_FFFF);
		settle();
		apb_write(REG_LOOP, 32'd1);
		tick(32'h0001_2345);

		// Random part in three idling phases; the last one starts with a long
		// receiver hold-off while request words keep coming.
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			in_idle = (ph == 0) ? 13 : (ph == 1) ? 74 : 0;
			out_idle = (ph == 0) ? 74 : (ph == 1) ? 13 : 0;
			apb_write(REG_PLAYING, 32'd1);
			case ($urandom_range(3))
				0: apb_write(REG_TPS, 32'd1);
				1: apb_write(REG_TPS, 32'd65535);
				default: apb_write(REG_TPS, $urandom_range(1, 16));
			endcase
			case ($urandom_range(3))
				0: apb_write(REG_LOOP, 32'd0);
				1: apb_write(REG_LOOP, 32'hFFFF_FFFF);
				default: apb_write(REG_LOOP, $urandom_range(32'h0010_0000, 32'h0100_0000));
			endcase
			if (ph == 2) begin
				hold_trig++;
				repeat (12) insert_key(1'($urandom), $urandom, $urandom, $urandom, $urandom);
			end
			target = words_sent + 310;
			while (words_sent < target) begin
				if ($urandom_range(99) < 80)
					keyframe_run();
				else
					noise_word();
				if (words_sent > target - 150 && words_sent < target - 140) begin
					settle();
					apb_write(REG_PLAYING, 32'd0);
					repeat (3) tick($urandom);
					settle();
					apb_write(REG_PLAYING, 32'd1);
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
